// ===== design/scaf_pkg.sv =====
// Shared types, constants and the set 1 key map for the scancode character queue.
package scaf_pkg;

  localparam int unsigned QUEUE_DEPTH = 64;
  localparam int unsigned PTR_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam logic [7:0]  BREAK_BIT   = 8'h80;
  localparam logic [7:0]  TABLE_LEN   = 8'h3A;

  typedef enum logic [1:0] {
    REQ_SCAN   = 2'd0,
    REQ_INJECT = 2'd1,
    REQ_READ   = 2'd2
  } req_e;

  typedef struct packed {
    logic capture;
    logic exec;
  } cmd_t;

  function automatic logic [PTR_W-1:0] advance(input logic [PTR_W-1:0] p);
    logic [PTR_W-1:0] r;
    if (p == PTR_W'(QUEUE_DEPTH - 1)) begin
      r = '0;
    end else begin
      r = p + PTR_W'(1);
    end
    return r;
  endfunction

  function automatic logic [7:0] key_map(input logic [5:0] code);
    logic [7:0] c;
    case (code)
      6'h02: c = "1";
      6'h03: c = "2";
      6'h04: c = "3";
      6'h05: c = "4";
      6'h06: c = "5";
      6'h07: c = "6";
      6'h08: c = "7";
      6'h09: c = "8";
      6'h0A: c = "9";
      6'h0B: c = "0";
      6'h0C: c = "-";
      6'h0D: c = "=";
      6'h0E: c = 8'h08;
      6'h0F: c = 8'h09;
      6'h10: c = "q";
      6'h11: c = "w";
      6'h12: c = "e";
      6'h13: c = "r";
      6'h14: c = "t";
      6'h15: c = "y";
      6'h16: c = "u";
      6'h17: c = "i";
      6'h18: c = "o";
      6'h19: c = "p";
      6'h1A: c = "[";
      6'h1B: c = "]";
      6'h1C: c = 8'h0A;
      6'h1E: c = "a";
      6'h1F: c = "s";
      6'h20: c = "d";
      6'h21: c = "f";
      6'h22: c = "g";
      6'h23: c = "h";
      6'h24: c = "j";
      6'h25: c = "k";
      6'h26: c = "l";
      6'h27: c = ";";
      6'h28: c = 8'h27;
      6'h29: c = 8'h60;
      6'h2B: c = 8'h5C;
      6'h2C: c = "z";
      6'h2D: c = "x";
      6'h2E: c = "c";
      6'h2F: c = "v";
      6'h30: c = "b";
      6'h31: c = "n";
      6'h32: c = "m";
      6'h33: c = ",";
      6'h34: c = ".";
      6'h35: c = "/";
      6'h37: c = "*";
      6'h39: c = " ";
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

// ===== design/scaf_ctrl.sv =====
// Controller state machine: input capture, execution slot and result register occupancy.
module scaf_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  output logic          res_valid_o,
  input  logic          res_ready_i,
  output scaf_pkg::cmd_t cmd_o
);
  import scaf_pkg::*;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_BUSY = 1'b1;

  logic state_q, state_d;
  logic out_full_q, out_full_d;
  logic exec;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign res_valid_o = out_full_q;
  assign exec        = (state_q == ST_BUSY) && (!out_full_q || res_ready_i);

  assign cmd_o.capture = in_valid_i && in_ready_o;
  assign cmd_o.exec    = exec;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = ST_BUSY;
        end
      end
      ST_BUSY: begin
        if (exec) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    if (exec) begin
      out_full_d = 1'b1;
    end else if (res_ready_i) begin
      out_full_d = 1'b0;
    end else begin
      out_full_d = out_full_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      out_full_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      out_full_q <= out_full_d;
    end
  end

`ifndef NO_ASSERTIONS
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (state_q == ST_BUSY))
    else $error("accepted beat did not start execution");
  a_exec_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    exec |=> (res_valid_o && in_ready_o))
    else $error("execution did not load the result register");
  a_exec_not_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(exec && in_ready_o))
    else $error("execution while idle");
`endif

endmodule

// ===== design/scaf_dp.sv =====
// Datapath: request registers, key map translation, character ring store and result register.
module scaf_dp (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  scaf_pkg::cmd_t cmd_i,
  input  logic [1:0]    req_type_i,
  input  logic [7:0]    in_byte_i,
  output logic [7:0]    out_char_o,
  output logic          out_valid_o,
  output logic          push_stored_o
);
  import scaf_pkg::*;

  logic [7:0]       mem [QUEUE_DEPTH];
  req_e             req_q;
  logic [7:0]       byte_q;
  logic [PTR_W-1:0] wptr_q, wptr_d;
  logic [PTR_W-1:0] rptr_q, rptr_d;
  logic [7:0]       char_q;
  logic             valid_q, stored_q;

  logic             full, empty;
  logic             push_req, push_en, pop_en;
  logic [7:0]       push_data;

  assign full  = (advance(wptr_q) == rptr_q);
  assign empty = (wptr_q == rptr_q);

  always_comb begin
    push_req  = 1'b0;
    push_data = byte_q;
    pop_en    = 1'b0;
    case (req_q)
      REQ_SCAN: begin
        push_data = key_map(byte_q[5:0]);
        push_req  = ((byte_q & BREAK_BIT) == 8'h00) && (byte_q < TABLE_LEN)
                    && (push_data != 8'h00);
      end
      REQ_INJECT: begin
        push_req = 1'b1;
      end
      REQ_READ: begin
        pop_en = cmd_i.exec && !empty;
      end
      default: begin
        push_req = 1'b0;
      end
    endcase
  end

  assign push_en = cmd_i.exec && push_req && !full;
  assign wptr_d  = push_en ? advance(wptr_q) : wptr_q;
  assign rptr_d  = pop_en ? advance(rptr_q) : rptr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      req_q  <= req_e'(req_type_i);
      byte_q <= in_byte_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_en) begin
      mem[wptr_q] <= push_data;
    end
    if (cmd_i.exec) begin
      char_q   <= pop_en ? mem[rptr_q] : 8'h00;
      valid_q  <= pop_en;
      stored_q <= push_en;
    end
  end

  assign out_char_o    = char_q;
  assign out_valid_o   = valid_q;
  assign push_stored_o = stored_q;

`ifndef NO_ASSERTIONS
  a_no_push_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push_en && pop_en))
    else $error("push and pop in the same beat");
  a_push_moves_wptr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_en |=> (wptr_q != $past(wptr_q)) && $stable(rptr_q))
    else $error("push did not advance the write pointer alone");
  a_idle_ptrs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !cmd_i.exec |=> $stable(wptr_q) && $stable(rptr_q))
    else $error("pointer moved outside execution");
`endif

endmodule

// ===== design/scancode_to_ascii_fifo_unit.sv =====
// Top level of the set 1 scancode to ASCII character queue.
//
//   Channel | Handshake                  | Payload
//   --------+----------------------------+------------------------------------------
//   input   | in_valid_i / in_ready_o    | req_type_i, in_byte_i
//   result  | res_valid_o / res_ready_i  | out_char_o, out_valid_o, push_stored_o
//
// Each beat has two steps: one to capture the request and one to translate it,
// update the ring pointers and access the single-port character store.
// A new beat is taken while a finished result still waits in the result register.
// Execution holds only while the result register is full and not being taken.
// Reset clears the pointers and control state; the character store needs no clearing.
module scancode_to_ascii_fifo_unit (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [1:0] req_type_i,
  input  logic [7:0] in_byte_i,
  output logic       res_valid_o,
  input  logic       res_ready_i,
  output logic [7:0] out_char_o,
  output logic       out_valid_o,
  output logic       push_stored_o
);
  import scaf_pkg::*;

  cmd_t cmd;

  scaf_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .res_valid_o (res_valid_o),
    .res_ready_i (res_ready_i),
    .cmd_o       (cmd)
  );

  scaf_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .req_type_i    (req_type_i),
    .in_byte_i     (in_byte_i),
    .out_char_o    (out_char_o),
    .out_valid_o   (out_valid_o),
    .push_stored_o (push_stored_o)
  );

endmodule
